// File: hdl/sbp_pkg.sv
// Shared types and constants for the step-gated Bernstein polynomial evaluator.
// Used by the divider cell, the de Casteljau cell and the top level.
`timescale 1ns / 1ps
package sbp_pkg;

    localparam int DEGREE    = 4;
    localparam int EFF_DEG   = (DEGREE < 0) ? 0 : ((DEGREE > 4) ? 4 : DEGREE);
    localparam int NUM_COEF  = 5;
    localparam int DIV_STEPS = 17;
    localparam int LATENCY   = 2 + DIV_STEPS + EFF_DEG + 1;

    localparam logic [2:0] REG_X_MIN  = 3'd0;
    localparam logic [2:0] REG_X_MAX  = 3'd1;
    localparam logic [2:0] REG_STEP   = 3'd2;
    localparam logic [2:0] REG_COEF_0 = 3'd3;
    localparam logic [2:0] REG_COEF_1 = 3'd4;
    localparam logic [2:0] REG_COEF_2 = 3'd5;
    localparam logic [2:0] REG_COEF_3 = 3'd6;
    localparam logic [2:0] REG_COEF_4 = 3'd7;

    typedef logic signed [31:0] coef_t;
    typedef coef_t [NUM_COEF-1:0] lanes_t;

    typedef struct packed {
        logic valid;
        logic below;
        logic rerr;
    } ctl_t;

endpackage

// File: hdl/sbp_div_cell.sv
// One quotient bit of the pipelined restoring divider.
// Depends on sbp_pkg for the sideband control type.
`timescale 1ns / 1ps
module sbp_div_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  sbp_pkg::ctl_t ctl_in,
    input  logic [49:0]   rem_in,
    input  logic [48:0]   den_in,
    input  logic [16:0]   q_in,
    output sbp_pkg::ctl_t ctl_out,
    output logic [49:0]   rem_out,
    output logic [48:0]   den_out,
    output logic [16:0]   q_out
);

    sbp_pkg::ctl_t ctl_reg;
    logic [49:0]   rem_reg;
    logic [49:0]   rem_next;
    logic [48:0]   den_reg;
    logic [16:0]   q_reg;
    logic [16:0]   q_next;
    logic [49:0]   diff;
    logic          ge;

    always_comb
    begin
        ge       = rem_in >= {1'b0, den_in};
        diff     = rem_in - {1'b0, den_in};
        rem_next = ge ? {diff[48:0], 1'b0} : {rem_in[48:0], 1'b0};
        q_next   = {q_in[15:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_in;
        q_reg   <= q_next;
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign q_out   = q_reg;

endmodule

// File: hdl/sbp_cjl_cell.sv
// One de Casteljau level: blends neighboring control points by the sample.
// Depends on sbp_pkg for the lane and control types.
`timescale 1ns / 1ps
module sbp_cjl_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  sbp_pkg::ctl_t  ctl_in,
    input  logic [16:0]    v_in,
    input  sbp_pkg::lanes_t p_in,
    output sbp_pkg::ctl_t  ctl_out,
    output logic [16:0]    v_out,
    output sbp_pkg::lanes_t p_out
);

    sbp_pkg::ctl_t   ctl_reg;
    logic [16:0]     v_reg;
    sbp_pkg::lanes_t p_reg;
    sbp_pkg::lanes_t p_next;
    logic [16:0]     sq;
    logic signed [49:0] sum [sbp_pkg::NUM_COEF-1];

    always_comb
    begin
        sq = 17'(17'd65536 - v_in);
        for (int i = 0; i < sbp_pkg::NUM_COEF - 1; i++)
        begin
            sum[i] = 50'(p_in[i]) * 50'(signed'({1'b0, sq}))
                   + 50'(p_in[i+1]) * 50'(signed'({1'b0, v_in}))
                   + 50'sd32768;
            p_next[i] = 32'(sum[i] >>> 16);
        end
        p_next[sbp_pkg::NUM_COEF-1] = p_in[sbp_pkg::NUM_COEF-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_in;
        p_reg <= p_next;
    end

    assign ctl_out = ctl_reg;
    assign v_out   = v_reg;
    assign p_out   = p_reg;

endmodule

// File: hdl/step_bernstein_poly_eval.sv
// Top level of the step-gated Bernstein polynomial evaluator.
// Depends on sbp_pkg, sbp_div_cell and sbp_cjl_cell.
// The pipeline has two front stages, 17 divider cells,
// one de Casteljau cell per degree and the output register.
// Throughput is one sample per cycle; busy stays low and results cannot be stalled.
// Reset clears all valid flags and loads the register defaults.
`timescale 1ns / 1ps
module step_bernstein_poly_eval (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] x_value,
    output logic               result_valid,
    output logic signed [31:0] value,
    output logic               below_step,
    output logic               range_error,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int ND = sbp_pkg::DIV_STEPS;
    localparam int NC = sbp_pkg::EFF_DEG;

    logic signed [31:0] x_min_reg;
    logic signed [31:0] x_max_reg;
    logic [15:0]        step_reg;
    sbp_pkg::lanes_t    coef_reg;

    logic               s1_valid_reg;
    logic signed [32:0] r_reg;
    logic signed [32:0] d_reg;

    logic               s2_valid_reg;
    logic               s2_rerr_reg;
    logic               s2_neg_reg;
    logic [47:0]        dsh_reg;
    logic [47:0]        sr_reg;
    logic [48:0]        den_reg;
    logic signed [32:0] dc;
    logic [31:0]        rc;

    logic               s3_below;

    sbp_pkg::ctl_t   div_ctl [ND+1];
    logic [49:0]     div_rem [ND+1];
    logic [48:0]     div_den [ND+1];
    logic [16:0]     div_q   [ND+1];

    sbp_pkg::ctl_t   cj_ctl [NC+1];
    logic [16:0]     cj_v   [NC+1];
    sbp_pkg::lanes_t cj_p   [NC+1];

    logic               out_valid_reg;
    logic signed [31:0] value_reg;
    logic               below_reg;
    logic               rerr_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg <= '0;
            x_max_reg <= 32'sd65536;
            step_reg  <= '0;
            coef_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sbp_pkg::REG_X_MIN:  x_min_reg   <= cfg_data;
                sbp_pkg::REG_X_MAX:  x_max_reg   <= cfg_data;
                sbp_pkg::REG_STEP:   step_reg    <= cfg_data[15:0];
                sbp_pkg::REG_COEF_0: coef_reg[0] <= cfg_data;
                sbp_pkg::REG_COEF_1: coef_reg[1] <= cfg_data;
                sbp_pkg::REG_COEF_2: coef_reg[2] <= cfg_data;
                sbp_pkg::REG_COEF_3: coef_reg[3] <= cfg_data;
                sbp_pkg::REG_COEF_4: coef_reg[4] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        dc       = (d_reg > r_reg) ? r_reg : d_reg;
        rc       = r_reg[31:0];
        s3_below = !s2_rerr_reg && (s2_neg_reg || (dsh_reg < sr_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg       <= 33'(x_max_reg) - 33'(x_min_reg);
        d_reg       <= 33'(x_value) - 33'(x_min_reg);
        s2_rerr_reg <= r_reg <= 33'sd0;
        s2_neg_reg  <= d_reg < 33'sd0;
        dsh_reg     <= {dc[31:0], 16'b0};
        sr_reg      <= 48'(step_reg) * 48'(rc);
        den_reg     <= 49'(rc) * 49'(17'(17'd65536 - 17'(step_reg)));
    end

    always_comb
    begin
        div_ctl[0].valid = s2_valid_reg;
        div_ctl[0].below = s3_below;
        div_ctl[0].rerr  = s2_rerr_reg;
        div_rem[0]       = (s3_below || s2_rerr_reg) ? 50'd0 : 50'(dsh_reg - sr_reg);
        div_den[0]       = (s3_below || s2_rerr_reg) ? 49'd1 : den_reg;
        div_q[0]         = '0;
    end

    for (genvar k = 0; k < ND; k++)
    begin : g_div
        sbp_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (div_ctl[k]),
            .rem_in  (div_rem[k]),
            .den_in  (div_den[k]),
            .q_in    (div_q[k]),
            .ctl_out (div_ctl[k+1]),
            .rem_out (div_rem[k+1]),
            .den_out (div_den[k+1]),
            .q_out   (div_q[k+1])
        );
    end

    assign cj_ctl[0] = div_ctl[ND];
    assign cj_v[0]   = div_q[ND];
    assign cj_p[0]   = coef_reg;

    for (genvar k = 0; k < NC; k++)
    begin : g_cjl
        sbp_cjl_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (cj_ctl[k]),
            .v_in    (cj_v[k]),
            .p_in    (cj_p[k]),
            .ctl_out (cj_ctl[k+1]),
            .v_out   (cj_v[k+1]),
            .p_out   (cj_p[k+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= cj_ctl[NC].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= (cj_ctl[NC].below || cj_ctl[NC].rerr) ? 32'sd0 : cj_p[NC][0];
        below_reg <= cj_ctl[NC].below;
        rerr_reg  <= cj_ctl[NC].rerr;
    end

    assign result_valid = out_valid_reg;
    assign value        = value_reg;
    assign below_step   = below_reg;
    assign range_error  = rerr_reg;

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(below_step && range_error))
        else $error("below_step and range_error both set");

    a_gated_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (below_step || range_error) |-> value == 32'sd0)
        else $error("gated result is not zero");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##(sbp_pkg::LATENCY) result_valid)
        else $error("result missing after pipeline latency");

endmodule

// File: tb/step_bernstein_poly_eval_tb.sv
// Self-checking testbench for step_bernstein_poly_eval: directed table, then random samples.
// Expected values come from a bit-exact predictor of the rescale, step test and de Casteljau sum.
// Depends on sbp_pkg and the step_bernstein_poly_eval RTL.
`timescale 1ns / 1ps
module step_bernstein_poly_eval_tb;

    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [31:0] value;
        logic               below;
        logic               rerr;
    } eval_t;

    typedef struct {
        logic signed [31:0] x;
        logic               known;
        logic signed [31:0] value;
        logic               below;
        logic               rerr;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] x_value;
    logic               result_valid;
    logic signed [31:0] value;
    logic               below_step;
    logic               range_error;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    longint m_xmin, m_xmax, m_step;
    longint m_coef [sbp_pkg::NUM_COEF];
    eval_t  pending [$];
    int     mismatches;
    longint cycles;

    step_bernstein_poly_eval dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("step_bernstein_poly_eval_tb: done, errors");
            $finish;
        end
    end

    function automatic longint floor16(longint t);
        longint q;
        q = t / 65536;
        if (t < 0 && (t % 65536) != 0)
            q--;
        return q;
    endfunction

    function automatic eval_t predict_poly(logic signed [31:0] x);
        eval_t  e;
        longint r, d, num, den, vq, sq;
        logic [63:0] unum, uden;
        longint p [sbp_pkg::NUM_COEF];
        e.value = '0;
        e.below = 1'b0;
        e.rerr  = 1'b0;
        r = m_xmax - m_xmin;
        d = longint'(x) - m_xmin;
        if (r <= 0)
            e.rerr = 1'b1;
        else
        begin
            if (d > r)
                d = r;
            if (d < 0 || d * 65536 < m_step * r)
                e.below = 1'b1;
            else
            begin
                num = d * 65536 - m_step * r;
                den = r * (65536 - m_step);
                unum = num;
                uden = den;
                vq = longint'((unum << 16) / uden);
                if (vq > 65536)
                    vq = 65536;
                sq = 65536 - vq;
                for (int i = 0; i < sbp_pkg::NUM_COEF; i++)
                    p[i] = m_coef[i];
                for (int lvl = sbp_pkg::EFF_DEG; lvl > 0; lvl--)
                    for (int i = 0; i < lvl; i++)
                        p[i] = floor16(p[i] * sq + p[i + 1] * vq + 32768);
                if (p[0] > 64'sd2147483647)
                    p[0] = 64'sd2147483647;
                if (p[0] < -64'sd2147483648)
                    p[0] = -64'sd2147483648;
                e.value = p[0][31:0];
            end
        end
        return e;
    endfunction

    always @(posedge clk)
    begin
        eval_t exp_e;
        if (rst_n && result_valid)
        begin
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: value %0d", value);
            end
            else
            begin
                exp_e = pending.pop_front();
                if (value !== exp_e.value || below_step !== exp_e.below
                    || range_error !== exp_e.rerr)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d/%b/%b got %0d/%b/%b", exp_e.value,
                            exp_e.below, exp_e.rerr, value, below_step, range_error);
                end
            end
        end
    end

    // Drops start for a random number of cycles; a zero-length gap leaves it high.
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            n = 0;
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            sbp_pkg::REG_X_MIN:  m_xmin = longint'(signed'(data));
            sbp_pkg::REG_X_MAX:  m_xmax = longint'(signed'(data));
            sbp_pkg::REG_STEP:   m_step = data[15:0];
            default:    m_coef[idx - sbp_pkg::REG_COEF_0] = longint'(signed'(data));
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending.size() != 0)
            @(posedge clk);
        repeat (sbp_pkg::LATENCY + 5) @(posedge clk);
    endtask

    // Drives one beat at the falling edge; start stays high through back-to-back beats.
    task automatic send_sample(logic signed [31:0] x, eval_t e);
        start   <= 1'b1;
        x_value <= x;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending.push_back(e);
        @(negedge clk);
    endtask

    task automatic release_start();
        start <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom_range(0, 1) ? 32'sh00010000 : 32'sh0;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(int count);
        logic signed [31:0] x;
        longint span;
        for (int k = 0; k < count; k++)
        begin
            span = m_xmax - m_xmin;
            if (span > 0 && $urandom_range(0, 3) != 0)
                x = 32'(m_xmin + ((span + 2) * longint'($urandom_range(0, 65535))) / 65536 - 1);
            else
                x = rand_word();
            send_sample(x, predict_poly(x));
            if ($urandom_range(0, 1) == 0)
                idle_gap();
        end
        release_start();
    endtask

    row_t table_rows [] = '{
        '{32'sh00000000, 1'b1, 32'sh0, 1'b0, 1'b0},
        '{32'sh00010000, 1'b1, 32'sh0, 1'b0, 1'b0},
        '{32'sh7fffffff, 1'b1, 32'sh0, 1'b0, 1'b0},
        '{32'sh80000000, 1'b1, 32'sh0, 1'b1, 1'b0},
        '{-32'sh1,       1'b1, 32'sh0, 1'b1, 1'b0},
        '{32'sh00008000, 1'b0, 32'sh0, 1'b0, 1'b0},
        '{32'sh00004000, 1'b0, 32'sh0, 1'b0, 1'b0},
        '{32'sh0000c000, 1'b0, 32'sh0, 1'b0, 1'b0},
        '{32'sh00000001, 1'b0, 32'sh0, 1'b0, 1'b0},
        '{32'sh0000ffff, 1'b0, 32'sh0, 1'b0, 1'b0},
        '{32'sh00020000, 1'b0, 32'sh0, 1'b0, 1'b0}
    };

    // The typed-in expectations hold only for the register defaults after reset.
    task automatic table_phase(bit use_known);
        eval_t e;
        foreach (table_rows[i])
        begin
            if (use_known && table_rows[i].known)
            begin
                e.value = table_rows[i].value;
                e.below = table_rows[i].below;
                e.rerr  = table_rows[i].rerr;
            end
            else
                e = predict_poly(table_rows[i].x);
            send_sample(table_rows[i].x, e);
            if (i % 3 == 0)
                idle_gap();
        end
        release_start();
        drain();
    endtask

    task automatic set_all(logic [31:0] xmin, logic [31:0] xmax, logic [31:0] stp,
                           logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
                           logic [31:0] c3, logic [31:0] c4);
        write_reg(sbp_pkg::REG_X_MIN, xmin);
        write_reg(sbp_pkg::REG_X_MAX, xmax);
        write_reg(sbp_pkg::REG_STEP, stp);
        write_reg(sbp_pkg::REG_COEF_0, c0);
        write_reg(sbp_pkg::REG_COEF_1, c1);
        write_reg(sbp_pkg::REG_COEF_2, c2);
        write_reg(sbp_pkg::REG_COEF_3, c3);
        write_reg(sbp_pkg::REG_COEF_4, c4);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        x_value = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cycles = 0;
        mismatches = 0;
        m_xmin = 0;
        m_xmax = 65536;
        m_step = 0;
        for (int i = 0; i < sbp_pkg::NUM_COEF; i++)
            m_coef[i] = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        table_phase(1'b1);
        set_all(32'h0, 32'h00010000, 32'h8000, 32'h00010000, 32'h00020000,
                32'hfffe0000, 32'h00030000, 32'h00040000);
        table_phase(1'b0);
        set_all(32'h80000000, 32'h7fffffff, 32'hffff, 32'h7fffffff, 32'h80000000,
                32'h7fffffff, 32'h80000000, 32'h7fffffff);
        random_phase(60);
        drain();
        set_all(32'h00050000, 32'h00050000, 32'h0, 32'h1, 32'h2, 32'h3, 32'h4, 32'h5);
        random_phase(30);
        drain();
        write_reg(sbp_pkg::REG_X_MAX, 32'h00010000);
        random_phase(20);
        drain();
        for (int ph = 0; ph < 8; ph++)
        begin
            set_all(rand_word(), rand_word(), $urandom, rand_word(), rand_word(),
                    rand_word(), rand_word(), rand_word());
            if (m_xmax <= m_xmin && $urandom_range(0, 3) != 0)
            begin
                write_reg(sbp_pkg::REG_X_MIN,
                          $urandom_range(0, 32'h7fff_ffff) - 32'sh4000_0000);
                write_reg(sbp_pkg::REG_X_MAX,
                          32'(m_xmin + 1 + $urandom_range(0, 32'h3fff_ffff)));
            end
            random_phase(80);
            drain();
        end

        if (mismatches == 0)
            $display("step_bernstein_poly_eval_tb: done, clean");
        else
            $display("step_bernstein_poly_eval_tb: done, errors");
        $finish;
    end
endmodule
